FILE: hdl/amp_crosstalk_pixel_correct_defines.svh
// Assertion macros for the amplifier crosstalk pixel correction block.
// Included by the top level; no other dependencies.
`ifndef AMP_CROSSTALK_PIXEL_CORRECT_DEFINES_SVH
`define AMP_CROSSTALK_PIXEL_CORRECT_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define AXT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("axtalk assertion failed");
// next-cycle implication
`define AXT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("axtalk assertion failed");
`else
`define AXT_ASSERT_IMP(label, clk, rst, ante, cons)
`define AXT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/axtalk_pkg.sv
// Shared types and constants for the amplifier crosstalk pixel correction block.
// No dependencies; used by axtalk_isqrt and amp_crosstalk_pixel_correct.
package axtalk_pkg;

   localparam int RegAddrWidth = 5;
   localparam int RegIdxWidth  = 3;

   // register indexes
   localparam logic [RegIdxWidth-1:0] REG_ICPT_A  = 3'd0;
   localparam logic [RegIdxWidth-1:0] REG_ICPT_B  = 3'd1;
   localparam logic [RegIdxWidth-1:0] REG_ICPT_C  = 3'd2;
   localparam logic [RegIdxWidth-1:0] REG_ICPT_D  = 3'd3;
   localparam logic [RegIdxWidth-1:0] REG_SLOPE_A = 3'd4;
   localparam logic [RegIdxWidth-1:0] REG_SLOPE_B = 3'd5;
   localparam logic [RegIdxWidth-1:0] REG_SLOPE_C = 3'd6;
   localparam logic [RegIdxWidth-1:0] REG_SLOPE_D = 3'd7;

   // amplifier codes
   localparam logic [1:0] AMP_A = 2'd0;
   localparam logic [1:0] AMP_B = 2'd1;
   localparam logic [1:0] AMP_C = 2'd2;
   localparam logic [1:0] AMP_D = 2'd3;

   // reset values: Q16.16 intercepts, slopes scaled by 2^40
   localparam logic signed [31:0] ICPT_A_RST  = 32'sd1181;
   localparam logic signed [31:0] ICPT_B_RST  = 32'sd10159;
   localparam logic signed [31:0] ICPT_C_RST  = -32'sd2515;
   localparam logic signed [31:0] ICPT_D_RST  = 32'sd12534;
   localparam logic signed [31:0] SLOPE_A_RST = -32'sd66514200;
   localparam logic signed [31:0] SLOPE_B_RST = -32'sd228107000;
   localparam logic signed [31:0] SLOPE_C_RST = -32'sd87632400;
   localparam logic signed [31:0] SLOPE_D_RST = -32'sd254836000;

   localparam logic signed [31:0] SciMax = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SciMin = 32'sh8000_0000;
   localparam logic [30:0]        ErrMax = 31'h7FFF_FFFF;

   // square root pipeline geometry
   localparam int RadWidth  = 64;
   localparam int RootWidth = 32;
   localparam int RemWidth  = RootWidth + 1;
   localparam int SqrtSteps = RadWidth / 2;

   // front stages + root stages + output register
   localparam int PipeLatency = 3 + SqrtSteps + 1;

   typedef struct packed {
      logic signed [31:0] sci_value;
      logic [30:0]        err_value;
      logic signed [31:0] mirror_value;
      logic               chip_one;
      logic               right_half;
   } req_type;

   typedef struct packed {
      logic signed [31:0] sci_out;
      logic [30:0]        err_out;
      logic               skipped;
      logic [1:0]         amp_index;
   } rsp_type;

   // side data carried alongside the root pipeline
   typedef struct packed {
      logic signed [31:0] sci_out;
      logic [30:0]        err_value;
      logic               skipped;
      logic [1:0]         amp_index;
   } sqrt_tag_type;

endpackage

FILE: hdl/amp_crosstalk_pixel_correct.sv
// Top level of the amplifier crosstalk pixel correction block.
// Depends on axtalk_pkg, axtalk_isqrt and amp_crosstalk_pixel_correct_defines.svh.
//
// Usage:
//   Requests enter on start with req_data (science, error, mirror value, chip
//   select, row half). busy is held low: a request may be issued on every
//   clock, so the block sustains one pixel per cycle.
//   Each request yields exactly one response on rsp_data, marked by a
//   one-cycle rsp_strobe, in request order. Between the accepting edge and
//   the edge that takes the response, a request passes three front stages
//   (multiply, round and form the correction, add and saturate), 32 stages of
//   the square root (one root bit per stage) and the output register. The
//   32-stage root pipeline is the deepest part; throughput is one per cycle.
//   The receiver cannot stall; responses are simply presented and not held.
//   Coefficients sit in eight 32-bit registers on the APB port: intercepts
//   A..D at 0x00..0x0C, slopes A..D at 0x10..0x1C. Write them only while no
//   requests are in flight. Reads return the stored value.
//   Reset is synchronous: it clears all pipeline valid bits, so any request
//   in flight is dropped, and reloads the coefficient defaults.
`include "amp_crosstalk_pixel_correct_defines.svh"

module amp_crosstalk_pixel_correct (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  axtalk_pkg::req_type                      req_data,
   output logic                                     rsp_strobe,
   output axtalk_pkg::rsp_type                      rsp_data,
   input  logic                                     psel,
   input  logic                                     penable,
   input  logic                                     pwrite,
   input  logic [axtalk_pkg::RegAddrWidth-1:0]      paddr,
   input  logic [31:0]                              pwdata,
   output logic [31:0]                              prdata,
   output logic                                     pready
);

   // ---------------------------------------------------------------
   // Coefficient registers
   // ---------------------------------------------------------------
   logic signed [31:0] icpt_a_ff, icpt_b_ff, icpt_c_ff, icpt_d_ff;
   logic signed [31:0] slope_a_ff, slope_b_ff, slope_c_ff, slope_d_ff;
   logic [axtalk_pkg::RegIdxWidth-1:0] reg_idx;
   logic csr_write;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[axtalk_pkg::RegAddrWidth-1:2];
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         icpt_a_ff  <= axtalk_pkg::ICPT_A_RST;
         icpt_b_ff  <= axtalk_pkg::ICPT_B_RST;
         icpt_c_ff  <= axtalk_pkg::ICPT_C_RST;
         icpt_d_ff  <= axtalk_pkg::ICPT_D_RST;
         slope_a_ff <= axtalk_pkg::SLOPE_A_RST;
         slope_b_ff <= axtalk_pkg::SLOPE_B_RST;
         slope_c_ff <= axtalk_pkg::SLOPE_C_RST;
         slope_d_ff <= axtalk_pkg::SLOPE_D_RST;
      end else if (csr_write) begin
         unique case (reg_idx)
            axtalk_pkg::REG_ICPT_A:  icpt_a_ff  <= pwdata;
            axtalk_pkg::REG_ICPT_B:  icpt_b_ff  <= pwdata;
            axtalk_pkg::REG_ICPT_C:  icpt_c_ff  <= pwdata;
            axtalk_pkg::REG_ICPT_D:  icpt_d_ff  <= pwdata;
            axtalk_pkg::REG_SLOPE_A: slope_a_ff <= pwdata;
            axtalk_pkg::REG_SLOPE_B: slope_b_ff <= pwdata;
            axtalk_pkg::REG_SLOPE_C: slope_c_ff <= pwdata;
            axtalk_pkg::REG_SLOPE_D: slope_d_ff <= pwdata;
         endcase
      end
   end

   // register read-back
   always_comb begin
      unique case (reg_idx)
         axtalk_pkg::REG_ICPT_A:  prdata = icpt_a_ff;
         axtalk_pkg::REG_ICPT_B:  prdata = icpt_b_ff;
         axtalk_pkg::REG_ICPT_C:  prdata = icpt_c_ff;
         axtalk_pkg::REG_ICPT_D:  prdata = icpt_d_ff;
         axtalk_pkg::REG_SLOPE_A: prdata = slope_a_ff;
         axtalk_pkg::REG_SLOPE_B: prdata = slope_b_ff;
         axtalk_pkg::REG_SLOPE_C: prdata = slope_c_ff;
         axtalk_pkg::REG_SLOPE_D: prdata = slope_d_ff;
      endcase
   end

   // ---------------------------------------------------------------
   // Stage 1: pick the amplifier, multiply mirror by slope, square error
   // ---------------------------------------------------------------
   logic               accept;
   logic [1:0]         amp_sel;
   logic signed [31:0] sel_icpt;
   logic signed [31:0] sel_slope;

   assign busy    = 1'b0;
   assign accept  = start & ~busy;
   assign amp_sel = {req_data.chip_one, req_data.right_half};

   always_comb begin
      unique case (amp_sel)
         axtalk_pkg::AMP_A: begin
            sel_icpt  = icpt_a_ff;
            sel_slope = slope_a_ff;
         end
         axtalk_pkg::AMP_B: begin
            sel_icpt  = icpt_b_ff;
            sel_slope = slope_b_ff;
         end
         axtalk_pkg::AMP_C: begin
            sel_icpt  = icpt_c_ff;
            sel_slope = slope_c_ff;
         end
         axtalk_pkg::AMP_D: begin
            sel_icpt  = icpt_d_ff;
            sel_slope = slope_d_ff;
         end
      endcase
   end

   logic               s1_valid_ff;
   logic signed [63:0] s1_prod_ff, s1_prod_in;
   logic [61:0]        s1_errsq_ff, s1_errsq_in;
   logic signed [31:0] s1_icpt_ff;
   logic signed [31:0] s1_sci_ff;
   logic [30:0]        s1_err_ff;
   logic [1:0]         s1_amp_ff;

   // product is exact and scaled by 2^56
   assign s1_prod_in  = req_data.mirror_value * sel_slope;
   assign s1_errsq_in = req_data.err_value * req_data.err_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_prod_ff  <= s1_prod_in;
      s1_errsq_ff <= s1_errsq_in;
      s1_icpt_ff  <= sel_icpt;
      s1_sci_ff   <= req_data.sci_value;
      s1_err_ff   <= req_data.err_value;
      s1_amp_ff   <= amp_sel;
   end

   // ---------------------------------------------------------------
   // Stage 2: round the product to Q16.16 (half toward plus infinity)
   // and form the correction, corr = -(intercept + term)
   // ---------------------------------------------------------------
   logic signed [63:0] s2_rounded;
   logic signed [23:0] s2_term;
   logic signed [33:0] s2_corr_in;

   assign s2_rounded = s1_prod_ff + (64'sd1 <<< 39);
   assign s2_term    = s2_rounded[63:40];
   assign s2_corr_in = 34'sd0 - (34'(s1_icpt_ff) + 34'(s2_term));

   logic               s2_valid_ff;
   logic signed [33:0] s2_corr_ff;
   logic [61:0]        s2_errsq_ff;
   logic signed [31:0] s2_sci_ff;
   logic [30:0]        s2_err_ff;
   logic [1:0]         s2_amp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_corr_ff  <= s2_corr_in;
      s2_errsq_ff <= s1_errsq_ff;
      s2_sci_ff   <= s1_sci_ff;
      s2_err_ff   <= s1_err_ff;
      s2_amp_ff   <= s1_amp_ff;
   end

   // ---------------------------------------------------------------
   // Stage 3: decide skip, saturate the science sum, build the radicand
   // err^2 + corr * 2^16
   // ---------------------------------------------------------------
   logic                                corr_pos;
   logic signed [34:0]                  sci_sum;
   logic signed [31:0]                  sci_sat;
   logic [axtalk_pkg::RadWidth-1:0]     s3_rad_in;
   axtalk_pkg::sqrt_tag_type            s3_tag_in;

   assign corr_pos = ~s2_corr_ff[33] & (s2_corr_ff != 34'sd0);
   assign sci_sum  = 35'(s2_sci_ff) + 35'(s2_corr_ff);

   always_comb begin
      priority if (sci_sum > 35'(axtalk_pkg::SciMax)) begin
         sci_sat = axtalk_pkg::SciMax;
      end else if (sci_sum < 35'(axtalk_pkg::SciMin)) begin
         sci_sat = axtalk_pkg::SciMin;
      end else begin
         sci_sat = sci_sum[31:0];
      end
   end

   always_comb begin
      // a positive correction stays below 2^32, so its low 32 bits suffice
      s3_rad_in = corr_pos
                ? (axtalk_pkg::RadWidth'(s2_errsq_ff) +
                   axtalk_pkg::RadWidth'({s2_corr_ff[31:0], 16'h0000}))
                : '0;
      s3_tag_in.sci_out   = corr_pos ? sci_sat : s2_sci_ff;
      s3_tag_in.err_value = s2_err_ff;
      s3_tag_in.skipped   = ~corr_pos;
      s3_tag_in.amp_index = s2_amp_ff;
   end

   logic                             s3_valid_ff;
   logic [axtalk_pkg::RadWidth-1:0]  s3_rad_ff;
   axtalk_pkg::sqrt_tag_type         s3_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_rad_ff <= s3_rad_in;
      s3_tag_ff <= s3_tag_in;
   end

   // ---------------------------------------------------------------
   // Square root, one root bit per stage
   // ---------------------------------------------------------------
   logic                              sq_valid;
   logic [axtalk_pkg::RootWidth-1:0]  sq_root;
   logic [axtalk_pkg::RemWidth-1:0]   sq_rem;
   axtalk_pkg::sqrt_tag_type          sq_tag;

   axtalk_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_rad    (s3_rad_ff),
      .in_tag    (s3_tag_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_rem   (sq_rem),
      .out_tag   (sq_tag)
   );

   // ---------------------------------------------------------------
   // Output: round the root to nearest, saturate, register the response
   // ---------------------------------------------------------------
   logic                                root_up;
   logic [axtalk_pkg::RemWidth-1:0]     root_rnd;
   logic [30:0]                         err_prop;
   axtalk_pkg::rsp_type                 rsp_data_in;
   axtalk_pkg::rsp_type                 rsp_data_ff;
   logic                                rsp_strobe_ff;

   // remainder above the root means the true root is past the half-way mark
   assign root_up  = (sq_rem > axtalk_pkg::RemWidth'(sq_root));
   assign root_rnd = axtalk_pkg::RemWidth'(sq_root) + axtalk_pkg::RemWidth'(root_up);
   assign err_prop = (root_rnd > axtalk_pkg::RemWidth'(axtalk_pkg::ErrMax))
                   ? axtalk_pkg::ErrMax : root_rnd[30:0];

   always_comb begin
      rsp_data_in.sci_out   = sq_tag.sci_out;
      rsp_data_in.err_out   = sq_tag.skipped ? sq_tag.err_value : err_prop;
      rsp_data_in.skipped   = sq_tag.skipped;
      rsp_data_in.amp_index = sq_tag.amp_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= sq_valid;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // every response traces back to a request a fixed latency earlier
   `AXT_ASSERT_IMP(a_rsp_has_req, clock, reset, rsp_strobe, $past(accept, axtalk_pkg::PipeLatency))
   // a skipped pixel returns its science value unchanged
   `AXT_ASSERT_IMP(a_skip_keeps_sci, clock, reset, rsp_strobe && rsp_data.skipped, rsp_data.sci_out == $past(req_data.sci_value, axtalk_pkg::PipeLatency))
   // a corrected pixel never reports a smaller error than it came in with
   `AXT_ASSERT_IMP(a_err_grows, clock, reset, rsp_strobe && !rsp_data.skipped, rsp_data.err_out >= $past(req_data.err_value, axtalk_pkg::PipeLatency))

endmodule

FILE: hdl/axtalk_isqrt.sv
// Pipelined integer square root, one result bit per stage, with side data.
// Depends on axtalk_pkg.
module axtalk_isqrt (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic [axtalk_pkg::RadWidth-1:0]     in_rad,
   input  axtalk_pkg::sqrt_tag_type            in_tag,
   output logic                                out_valid,
   output logic [axtalk_pkg::RootWidth-1:0]    out_root,
   output logic [axtalk_pkg::RemWidth-1:0]     out_rem,
   output axtalk_pkg::sqrt_tag_type            out_tag
);

   localparam int N   = axtalk_pkg::SqrtSteps;
   localparam int RW  = axtalk_pkg::RadWidth;
   localparam int QW  = axtalk_pkg::RootWidth;
   localparam int MW  = axtalk_pkg::RemWidth;
   localparam int CW  = MW + 2;

   logic                     valid_ff [0:N-1];
   logic [MW-1:0]            rem_ff   [0:N-1];
   logic [QW-1:0]            root_ff  [0:N-1];
   axtalk_pkg::sqrt_tag_type tag_ff   [0:N-1];
   logic [RW-1:0]            rad_ff   [0:N-2];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic                     prev_valid;
      logic [MW-1:0]            prev_rem;
      logic [QW-1:0]            prev_root;
      logic [RW-1:0]            prev_rad;
      axtalk_pkg::sqrt_tag_type prev_tag;
      logic [CW-1:0]            cur_rem;
      logic [CW-1:0]            trial;
      logic                     take;
      logic [MW-1:0]            rem_in;
      logic [QW-1:0]            root_in;

      if (k == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_rem   = '0;
         assign prev_root  = '0;
         assign prev_rad   = in_rad;
         assign prev_tag   = in_tag;
      end else begin : g_next
         assign prev_valid = valid_ff[k-1];
         assign prev_rem   = rem_ff[k-1];
         assign prev_root  = root_ff[k-1];
         assign prev_rad   = rad_ff[k-1];
         assign prev_tag   = tag_ff[k-1];
      end

      // bring down the next two radicand bits and try the next root bit
      always_comb begin
         cur_rem = {prev_rem, prev_rad[RW-1 -: 2]};
         trial   = CW'({prev_root, 2'b01});
         take    = (cur_rem >= trial);
         rem_in  = take ? MW'(cur_rem - trial) : MW'(cur_rem);
         root_in = {prev_root[QW-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= prev_valid;
         end
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         tag_ff[k]  <= prev_tag;
      end

      if (k < N - 1) begin : g_rad
         always_ff @(posedge clock) begin
            rad_ff[k] <= {prev_rad[RW-3:0], 2'b00};
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_root  = root_ff[N-1];
   assign out_rem   = rem_ff[N-1];
   assign out_tag   = tag_ff[N-1];

endmodule

FILE: tb/sv/amp_crosstalk_pixel_correct_checker.sv
// Prediction and response check for the amplifier crosstalk pixel correction block.
// Depends on axtalk_pkg; watches the request, response and APB channels from outside.
module amp_crosstalk_pixel_correct_checker
   import axtalk_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    busy,
   input  req_type                 req_data,
   input  logic                    rsp_strobe,
   input  rsp_type                 rsp_data,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [RegAddrWidth-1:0] paddr,
   input  logic [31:0]             pwdata,
   input  logic [31:0]             prdata,
   input  logic                    pready,
   output int                      mismatches,
   output int                      outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   logic signed [31:0] intercept [4];
   logic signed [31:0] slope [4];
   rsp_type            pixels_due [$];
   rsp_type            want;
   int                 fault_count = 0;
   logic [2:0]         reg_idx;
   logic [31:0]        reg_value;

   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   function automatic rsp_type correct_pixel(input req_type px);
      logic [1:0]        amp;
      longint signed     product;
      longint signed     term;
      longint signed     corr;
      longint signed     sum;
      longint unsigned   corr_bits;
      longint unsigned   err_wide;
      longint unsigned   radicand;
      longint unsigned   root;
      rsp_type           res;
      amp       = {px.chip_one, px.right_half};
      product   = longint'(px.mirror_value) * longint'(slope[amp]);
      // round half up, then floor back to Q16.16
      term      = (product + 64'sh0000_0080_0000_0000) >>> 40;
      corr      = -(longint'(intercept[amp]) + term);
      res.amp_index = amp;
      if (corr > 0) begin
         sum = longint'(px.sci_value) + corr;
         if (sum > longint'(SciMax)) sum = longint'(SciMax);
         if (sum < longint'(SciMin)) sum = longint'(SciMin);
         err_wide  = {33'd0, px.err_value};
         corr_bits = corr;
         radicand  = err_wide * err_wide + (corr_bits << 16);
         root      = floor_root(radicand);
         if (radicand - root * root > root) root++;
         if (root > {33'd0, ErrMax}) root = {33'd0, ErrMax};
         res.sci_out = sum[31:0];
         res.err_out = root[30:0];
         res.skipped = 1'b0;
      end else begin
         res.sci_out = px.sci_value;
         res.err_out = px.err_value;
         res.skipped = 1'b1;
      end
      return res;
   endfunction

   task automatic report_fault(input string detail);
      fault_count++;
      if (fault_count <= 10) $display("[%0t] check: %s", $time, detail);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pixels_due.delete();
         intercept[AMP_A] = ICPT_A_RST;
         intercept[AMP_B] = ICPT_B_RST;
         intercept[AMP_C] = ICPT_C_RST;
         intercept[AMP_D] = ICPT_D_RST;
         slope[AMP_A]     = SLOPE_A_RST;
         slope[AMP_B]     = SLOPE_B_RST;
         slope[AMP_C]     = SLOPE_C_RST;
         slope[AMP_D]     = SLOPE_D_RST;
      end else begin
         reg_idx = paddr[RegAddrWidth-1:2];
         if (reg_idx >= REG_SLOPE_A) reg_value = slope[reg_idx - REG_SLOPE_A];
         else reg_value = intercept[reg_idx];
         if (psel && penable && pready && !pwrite && prdata !== reg_value)
            report_fault($sformatf("register %0d read %h, expected %h",
                                   reg_idx, prdata, reg_value));
         if (psel && penable && pready && pwrite) begin
            if (reg_idx >= REG_SLOPE_A) slope[reg_idx - REG_SLOPE_A] = pwdata;
            else intercept[reg_idx] = pwdata;
         end
         if (rsp_strobe) begin
            if (pixels_due.size() == 0) begin
               report_fault($sformatf("unexpected response %h", rsp_data));
            end else begin
               want = pixels_due.pop_front();
               if (rsp_data.sci_out !== want.sci_out || rsp_data.err_out !== want.err_out ||
                   rsp_data.skipped !== want.skipped ||
                   rsp_data.amp_index !== want.amp_index)
                  report_fault($sformatf(
                     "sci %h/%h err %h/%h skipped %b/%b amp %0d/%0d (expected/actual)",
                     want.sci_out, rsp_data.sci_out, want.err_out, rsp_data.err_out,
                     want.skipped, rsp_data.skipped, want.amp_index, rsp_data.amp_index));
            end
         end
         if (start && !busy) pixels_due.push_back(correct_pixel(req_data));
      end
      mismatches  <= fault_count;
      outstanding <= pixels_due.size();
   end

endmodule

FILE: tb/sv/amp_crosstalk_pixel_correct_test.sv
// Stimulus and verdict for the amplifier crosstalk pixel correction block.
// Depends on axtalk_pkg, the block itself and amp_crosstalk_pixel_correct_checker.
module amp_crosstalk_pixel_correct_test;
   timeunit 1ns;
   timeprecision 1ps;
   import axtalk_pkg::*;

   typedef enum {SET_LOW, SET_HIGH, SET_ZERO, SET_RANDOM, SET_DEFAULT} coeff_plan_type;

   localparam int RandomPerPhase = 85;
   localparam int CalmTail       = 45;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    start;
   logic                    busy;
   req_type                 req_data;
   logic                    rsp_strobe;
   rsp_type                 rsp_data;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [RegAddrWidth-1:0] paddr;
   logic [31:0]             pwdata;
   logic [31:0]             prdata;
   logic                    pready;
   int                      mismatches;
   int                      outstanding;

   logic signed [31:0]      icpt_set [4];
   logic signed [31:0]      slope_set [4];
   coeff_plan_type          plan [6] = '{SET_LOW, SET_HIGH, SET_ZERO, SET_RANDOM, SET_RANDOM,
                                         SET_DEFAULT};

   always #5ns clock = ~clock;

   amp_crosstalk_pixel_correct DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   amp_crosstalk_pixel_correct_checker pixel_check (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // Hand one request over and hold it until the block takes it. Optionally
   // drop start afterwards for a short random burst so that gaps land on
   // every stage of the pipeline.
   task automatic issue_pixel(input req_type px, input bit may_idle);
      start    <= 1'b1;
      req_data <= px;
      do @(posedge clock); while (busy);
      if (may_idle && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic issue_fields(input logic signed [31:0] sci, input logic [30:0] err,
                               input logic signed [31:0] mirror, input logic [1:0] amp);
      req_type px;
      px.sci_value    = sci;
      px.err_value    = err;
      px.mirror_value = mirror;
      px.chip_one     = amp[1];
      px.right_half   = amp[0];
      issue_pixel(px, 1'b1);
   endtask

   // One APB transfer: setup phase, then access phase until pready, then an idle
   // phase with psel low so the next transfer starts on a fresh edge.
   task automatic csr_access(input bit wr, input logic [2:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Field values lean towards the extremes and towards small magnitudes,
   // where the correction changes sign and rounding matters most.
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 5))
         0:       return SciMax;
         1:       return SciMin;
         2:       return $urandom_range(0, 200000) - 100000;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_pixel();
      req_type px;
      px.sci_value    = pick_word();
      px.mirror_value = pick_word();
      case ($urandom_range(0, 4))
         0:       px.err_value = ErrMax;
         1:       px.err_value = '0;
         2:       px.err_value = 31'($urandom_range(0, 1 << 20));
         default: px.err_value = 31'($urandom);
      endcase
      px.chip_one   = 1'($urandom_range(0, 1));
      px.right_half = 1'($urandom_range(0, 1));
      return px;
   endfunction

   // Let the pipeline drain before anything touches the coefficients.
   task automatic drain_pipeline();
      int waited;
      waited = 0;
      repeat (2) @(posedge clock);
      while (outstanding != 0 && waited < 4 * PipeLatency) begin
         @(posedge clock);
         waited++;
      end
   endtask

   task automatic load_coefficients(input coeff_plan_type kind);
      for (int a = 0; a < 4; a++) begin
         case (kind)
            SET_LOW: begin
               icpt_set[a]  = SciMin;
               slope_set[a] = SciMin;
            end
            SET_HIGH: begin
               icpt_set[a]  = SciMax;
               slope_set[a] = SciMax;
            end
            SET_ZERO: begin
               icpt_set[a]  = '0;
               slope_set[a] = '0;
            end
            SET_RANDOM: begin
               icpt_set[a]  = pick_word();
               slope_set[a] = pick_word();
            end
            default: begin
               icpt_set[a]  = '0;
               slope_set[a] = '0;
            end
         endcase
      end
      if (kind == SET_DEFAULT) begin
         icpt_set  = '{ICPT_A_RST, ICPT_B_RST, ICPT_C_RST, ICPT_D_RST};
         slope_set = '{SLOPE_A_RST, SLOPE_B_RST, SLOPE_C_RST, SLOPE_D_RST};
      end
      for (int a = 0; a < 4; a++) begin
         csr_access(1'b1, REG_ICPT_A + 3'(a), icpt_set[a]);
         csr_access(1'b1, REG_SLOPE_A + 3'(a), slope_set[a]);
      end
      // read back every register; the checker holds its own copy to compare
      for (int a = 0; a < 4; a++) begin
         csr_access(1'b0, REG_ICPT_A + 3'(a), '0);
         csr_access(1'b0, REG_SLOPE_A + 3'(a), '0);
      end
   endtask

   // Hard stop in case the block never answers.
   initial begin
      #1ms;
      $display("amp_crosstalk_pixel_correct: mismatch");
      $finish;
   end

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      psel     = 1'b0;
      penable  = 1'b0;
      pwrite   = 1'b0;
      paddr    = '0;
      pwdata   = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests on the default coefficients: zero pixel on a
      // skipping and a correcting amplifier, saturation of science and error,
      // negative mirror values that leave the pixel untouched, every amplifier.
      issue_fields('0, '0, '0, AMP_A);
      issue_fields('0, '0, '0, AMP_C);
      issue_fields(SciMax, ErrMax, SciMax, AMP_A);
      issue_fields(SciMax, '0, SciMax, AMP_B);
      issue_fields(SciMin, ErrMax, SciMax, AMP_C);
      issue_fields(SciMin, '0, SciMin, AMP_D);
      issue_fields(32'sd65536, 31'd65536, SciMin, AMP_A);
      issue_fields('0, '0, SciMax, AMP_D);
      issue_fields(32'sd1000, 31'd1, -32'sd1, AMP_B);
      issue_fields(-32'sd1000, 31'd1, 32'sd1, AMP_C);
      issue_fields('0, ErrMax, SciMin, AMP_B);
      issue_fields(32'sh7FFF_0000, 31'd12345, SciMax, AMP_D);
      issue_fields(-32'sd1, 31'd1, 32'sh0001_0000, AMP_A);
      repeat (RandomPerPhase) issue_pixel(random_pixel(), 1'b1);
      start <= 1'b0;

      // Step through the coefficient settings, extremes first.
      foreach (plan[p]) begin
         drain_pipeline();
         load_coefficients(plan[p]);
         if (plan[p] == SET_ZERO) begin
            // correction exactly zero: the pixel must pass as skipped
            issue_fields(SciMax, ErrMax, SciMax, AMP_A);
            issue_fields(SciMin, '0, SciMin, AMP_D);
         end
         for (int i = 0; i < RandomPerPhase; i++)
            issue_pixel(random_pixel(),
                        p != $size(plan) - 1 || i < RandomPerPhase - CalmTail);
         start <= 1'b0;
      end

      drain_pipeline();
      repeat (PipeLatency + 4) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("amp_crosstalk_pixel_correct: match");
      end else begin
         $display("amp_crosstalk_pixel_correct: mismatch");
      end
      $finish;
   end

endmodule
